// ===== design/vrts_pkg.sv =====
// vrts_pkg: shared types for the velocity ramp trajectory sampler.
// Word layouts, controller states and controller/datapath command and status.
package vrts_pkg;

  localparam int DIV_STEPS = 48;   // quotient bits of (dv << 16) / a
  localparam int CNT_W     = 6;

  typedef struct packed {
    logic [2:0]         axis;
    logic               first_axis;
    logic               selected;
    logic signed [31:0] current_position;
    logic signed [31:0] current_velocity;
    logic signed [31:0] current_accel;
    logic signed [31:0] target_velocity;
    logic [31:0]        max_accel;
    logic [31:0]        sample_time;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         axis_out;
    logic signed [31:0] new_position;
    logic signed [31:0] new_velocity;
    logic signed [31:0] new_accel;
    logic signed [31:0] position_at_target;
    logic [31:0]        ramp_time;
    logic               working;
    logic               any_working;
    logic [31:0]        greatest_time;
    logic [2:0]         greatest_axis;
    logic               accel_zero;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_M_AT, ST_W_VT, ST_M_PT, ST_W_PT, ST_M_AV, ST_W_V,
    ST_M_PV, ST_W_P, ST_M_H, ST_W_H, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_AT, MUL_PT, MUL_AV, MUL_PV, MUL_HOLD
  } mul_sel_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_VT, WB_PT, WB_V, WB_P, WB_H
  } wb_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     mul_en;
    mul_sel_t mul_sel;
    wb_sel_t  wb_sel;
    logic     fin;
  } cmd_t;

  typedef struct packed {
    logic sel_in;     // incoming word is a controlled axis
    logic work;       // sample time within ramp
    logic out_free;   // output register can take a word this cycle
  } sts_t;

endpackage

// ===== design/velocity_ramp_trajectory_sampler.sv =====
// velocity_ramp_trajectory_sampler: top level, joins controller and datapath.
// Depends on vrts_pkg, vrts_ctrl and vrts_datapath.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_word) takes one axis word. The
//    block works on one word at a time; in_stall is high from acceptance
//    until the result has moved into the output register.
//  - Output channel (out_valid / out_stall / out_word) presents one result
//    word per input word. The output register lets the next input word be
//    taken while a finished result still waits for the receiver.
//  - Selected axis: a one-bit-per-cycle restoring divider for the ramp
//    time, then multiply / write-back pairs on the shared 33x32 multiplier
//    (four pairs inside the ramp, three in the hold), then the finish state.
//  - Unselected axis (or axis index at or above NUM_AXES): pass-through,
//    straight from the idle state to the finish state.
//  - A new word is taken only in the idle state, once the previous word
//    has moved from the finish state into the output register.
//  - A stalled receiver holds the word in the output register; a second
//    finished word waits in the finish state until the register frees.
//  - Reset clears the running maximum, its axis, the working flag and the
//    output valid; the block then takes words at once.
module velocity_ramp_trajectory_sampler #(
  parameter int NUM_AXES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vrts_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output vrts_pkg::out_word_t out_word
);

  vrts_pkg::cmd_t cmd;
  vrts_pkg::sts_t sts;

  vrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vrts_datapath #(
    .NUM_AXES (NUM_AXES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== design/vrts_ctrl.sv =====
// vrts_ctrl: sequencing state machine of the sampler.
// Depends on vrts_pkg; drives vrts_datapath through cmd_t.
module vrts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  vrts_pkg::sts_t  sts,
  output vrts_pkg::cmd_t  cmd
);

  vrts_pkg::state_t state_r, state_nxt;
  logic [vrts_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vrts_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      vrts_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = sts.sel_in ? vrts_pkg::ST_DIV : vrts_pkg::ST_FIN;
        end
      end
      vrts_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == vrts_pkg::CNT_W'(vrts_pkg::DIV_STEPS - 1)) begin
          state_nxt = vrts_pkg::ST_M_AT;
        end
      end
      vrts_pkg::ST_M_AT: state_nxt = vrts_pkg::ST_W_VT;
      vrts_pkg::ST_W_VT: state_nxt = vrts_pkg::ST_M_PT;
      vrts_pkg::ST_M_PT: state_nxt = vrts_pkg::ST_W_PT;
      vrts_pkg::ST_W_PT: state_nxt = sts.work ? vrts_pkg::ST_M_AV : vrts_pkg::ST_M_H;
      vrts_pkg::ST_M_AV: state_nxt = vrts_pkg::ST_W_V;
      vrts_pkg::ST_W_V:  state_nxt = vrts_pkg::ST_M_PV;
      vrts_pkg::ST_M_PV: state_nxt = vrts_pkg::ST_W_P;
      vrts_pkg::ST_W_P:  state_nxt = vrts_pkg::ST_FIN;
      vrts_pkg::ST_M_H:  state_nxt = vrts_pkg::ST_W_H;
      vrts_pkg::ST_W_H:  state_nxt = vrts_pkg::ST_FIN;
      vrts_pkg::ST_FIN: begin
        if (sts.out_free) state_nxt = vrts_pkg::ST_IDLE;
      end
      default: state_nxt = vrts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != vrts_pkg::ST_IDLE);
    cmd          = '0;
    cmd.mul_sel  = vrts_pkg::MUL_AT;
    cmd.wb_sel   = vrts_pkg::WB_NONE;
    unique case (state_r)
      vrts_pkg::ST_IDLE: cmd.load = in_valid;
      vrts_pkg::ST_DIV:  cmd.div_step = 1'b1;
      vrts_pkg::ST_M_AT: begin cmd.mul_en = 1'b1; cmd.mul_sel = vrts_pkg::MUL_AT;   end
      vrts_pkg::ST_M_PT: begin cmd.mul_en = 1'b1; cmd.mul_sel = vrts_pkg::MUL_PT;   end
      vrts_pkg::ST_M_AV: begin cmd.mul_en = 1'b1; cmd.mul_sel = vrts_pkg::MUL_AV;   end
      vrts_pkg::ST_M_PV: begin cmd.mul_en = 1'b1; cmd.mul_sel = vrts_pkg::MUL_PV;   end
      vrts_pkg::ST_M_H:  begin cmd.mul_en = 1'b1; cmd.mul_sel = vrts_pkg::MUL_HOLD; end
      vrts_pkg::ST_W_VT: cmd.wb_sel = vrts_pkg::WB_VT;
      vrts_pkg::ST_W_PT: cmd.wb_sel = vrts_pkg::WB_PT;
      vrts_pkg::ST_W_V:  cmd.wb_sel = vrts_pkg::WB_V;
      vrts_pkg::ST_W_P:  cmd.wb_sel = vrts_pkg::WB_P;
      vrts_pkg::ST_W_H:  cmd.wb_sel = vrts_pkg::WB_H;
      vrts_pkg::ST_FIN:  cmd.fin = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/vrts_datapath.sv =====
// vrts_datapath: operand registers, restoring divider, shared multiplier,
// set tracking and the output register. Depends on vrts_pkg.
module vrts_datapath #(
  parameter int NUM_AXES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vrts_pkg::in_word_t  in_word,
  input  vrts_pkg::cmd_t      cmd,
  output vrts_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_stall,
  output vrts_pkg::out_word_t out_word
);

  // saturating p + floor(+-prod / 2^sh), sh is 17 or 16
  function automatic logic signed [31:0] add_sat(input logic signed [31:0] base,
                                                 input logic neg,
                                                 input logic [64:0] prod,
                                                 input logic sh17);
    logic [64:0]        q;
    logic signed [49:0] sum;
    if (sh17) q = neg ? ((prod + 65'h1FFFF) >> 17) : (prod >> 17);
    else      q = neg ? ((prod + 65'hFFFF) >> 16)  : (prod >> 16);
    if (neg) sum = 50'(base) - $signed({1'b0, q[48:0]});
    else     sum = 50'(base) + $signed({1'b0, q[48:0]});
    if (sum > 50'sd2147483647)       add_sat = 32'sh7FFFFFFF;
    else if (sum < -50'sd2147483648) add_sat = 32'sh80000000;
    else                             add_sat = sum[31:0];
  endfunction

  logic [2:0]         axis_r;
  logic               first_r, sel_r, up_r;
  logic signed [31:0] p0_r, v0_r, acur_r, vt_r, np_r, pt_r, nv_r;
  logic [31:0]        a_r, t_r;
  logic [47:0]        dvd_r;       // dividend bits out, quotient bits in
  logic [31:0]        rem_r;
  logic [64:0]        prod_r;
  logic [31:0]        max_time_r;
  logic [2:0]         max_axis_r;
  logic               any_work_r, out_valid_r;
  vrts_pkg::out_word_t out_r;

  // input side
  logic signed [32:0] dv_diff;
  logic               up_in;
  logic [31:0]        dv_in;
  always_comb begin
    up_in   = (in_word.current_velocity <= in_word.target_velocity);
    dv_diff = 33'(in_word.target_velocity) - 33'(in_word.current_velocity);
    dv_in   = up_in ? dv_diff[31:0] : 32'(-dv_diff);
  end

  // divider step; remainder stays below the divisor, so 32 bits hold it
  logic [32:0] rem_sh, rem_sub;
  logic        q_bit;
  always_comb begin
    rem_sh  = {rem_r, dvd_r[47]};
    rem_sub = rem_sh - {1'b0, a_r};
    q_bit   = (rem_sh >= {1'b0, a_r});
  end

  logic [31:0] ramp_t;
  assign ramp_t = (|dvd_r[47:32]) ? 32'hFFFFFFFF : dvd_r[31:0];

  logic work_c;
  assign work_c = (t_r <= ramp_t);

  // velocity sums and magnitudes
  logic signed [32:0] s_t, s_v, s_h;
  logic [32:0]        m_t, m_v, m_h;
  always_comb begin
    s_t = 33'(v0_r) + 33'(vt_r);   // vt_r holds v(T) after WB_VT
    s_v = 33'(v0_r) + 33'(nv_r);
    s_h = 33'(vt_r);
    m_t = s_t[32] ? 33'(-s_t) : s_t;
    m_v = s_v[32] ? 33'(-s_v) : s_v;
    m_h = s_h[32] ? 33'(-s_h) : s_h;
  end

  logic [32:0] op_a;
  logic [31:0] op_b;
  always_comb begin
    case (cmd.mul_sel)
      vrts_pkg::MUL_AT:   begin op_a = {1'b0, a_r}; op_b = ramp_t;          end
      vrts_pkg::MUL_PT:   begin op_a = m_t;         op_b = ramp_t;          end
      vrts_pkg::MUL_AV:   begin op_a = {1'b0, a_r}; op_b = t_r;             end
      vrts_pkg::MUL_PV:   begin op_a = m_v;         op_b = t_r;             end
      vrts_pkg::MUL_HOLD: begin op_a = m_h;         op_b = t_r - ramp_t;    end
      default:            begin op_a = '0;          op_b = '0;              end
    endcase
  end

  logic signed [33:0] vel_c;
  always_comb begin
    if (up_r) vel_c = 34'(v0_r) + $signed({2'b0, prod_r[47:16]});
    else      vel_c = 34'(v0_r) - $signed({2'b0, prod_r[47:16]});
  end

  logic signed [31:0] na_c;
  always_comb begin
    if (up_r)                   na_c = a_r[31] ? 32'sh7FFFFFFF : $signed(a_r);
    else if (a_r > 32'h80000000) na_c = 32'sh80000000;
    else                        na_c = $signed(32'(-a_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      axis_r  <= in_word.axis;
      first_r <= in_word.first_axis;
      sel_r   <= sts.sel_in;
      up_r    <= up_in;
      p0_r    <= in_word.current_position;
      v0_r    <= in_word.current_velocity;
      acur_r  <= in_word.current_accel;
      vt_r    <= in_word.target_velocity;
      a_r     <= in_word.max_accel;
      t_r     <= in_word.sample_time;
      dvd_r   <= {dv_in, 16'h0};
      rem_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
      dvd_r <= {dvd_r[46:0], q_bit};
    end
    if (cmd.mul_en) prod_r <= {32'b0, op_a} * {33'b0, op_b};
    case (cmd.wb_sel)
      vrts_pkg::WB_VT: vt_r <= vel_c[31:0];
      vrts_pkg::WB_PT: pt_r <= add_sat(p0_r, s_t[32], prod_r, 1'b1);
      vrts_pkg::WB_V:  nv_r <= vel_c[31:0];
      vrts_pkg::WB_P:  np_r <= add_sat(p0_r, s_v[32], prod_r, 1'b1);
      vrts_pkg::WB_H:  np_r <= add_sat(pt_r, s_h[32], prod_r, 1'b0);
      default: ;
    endcase
  end

  // set tracking and result assembly
  logic [31:0] mt_base, mt_nxt;
  logic [2:0]  ma_base, ma_nxt;
  logic        aw_nxt;
  vrts_pkg::out_word_t res;
  always_comb begin
    mt_base = first_r ? 32'h0 : max_time_r;
    ma_base = first_r ? 3'h0  : max_axis_r;
    aw_nxt  = first_r ? 1'b0  : any_work_r;
    mt_nxt  = mt_base;
    ma_nxt  = ma_base;
    res     = '0;
    res.axis_out = axis_r;
    if (sel_r) begin
      if (ramp_t > mt_base) begin
        mt_nxt = ramp_t;
        ma_nxt = axis_r;
      end
      aw_nxt                 = aw_nxt | work_c;
      res.new_position       = np_r;
      res.new_velocity       = work_c ? nv_r : vt_r;
      res.new_accel          = work_c ? na_c : 32'sh0;
      res.position_at_target = pt_r;
      res.ramp_time          = ramp_t;
      res.working            = work_c;
      res.accel_zero         = (a_r == 32'h0);
    end else begin
      res.new_position       = p0_r;
      res.new_velocity       = v0_r;
      res.new_accel          = acur_r;
      res.position_at_target = p0_r;
    end
    res.any_working   = aw_nxt;
    res.greatest_time = mt_nxt;
    res.greatest_axis = ma_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_time_r  <= '0;
      max_axis_r  <= '0;
      any_work_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fin) begin
        max_time_r  <= mt_nxt;
        max_axis_r  <= ma_nxt;
        any_work_r  <= aw_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) out_r <= res;
  end

  always_comb begin
    sts.sel_in   = in_word.selected && (32'(in_word.axis) < NUM_AXES);
    sts.work     = work_c;
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

// ===== tb/velocity_ramp_trajectory_sampler_tb.sv =====
`timescale 1ns / 1ps
// Testbench for velocity_ramp_trajectory_sampler: directed and random axis words,
// each predicted in Q16.16 on acceptance and checked field by field. Needs vrts_pkg.
module velocity_ramp_trajectory_sampler_tb;

  localparam int NUM_AXES  = 8;
  localparam int N_RANDOM  = 2000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  vrts_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  vrts_pkg::out_word_t out_word;

  velocity_ramp_trajectory_sampler #(.NUM_AXES(NUM_AXES)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  // 4 ns clock
  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  vrts_pkg::in_word_t  pending_words[$];    // words waiting for the driver
  vrts_pkg::out_word_t expected_samples[$]; // predicted results, oldest first

  // set state of the predictor
  bit [31:0] set_max_time;
  bit [2:0]  set_max_axis;
  bit        set_working;

  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 46;
  int unsigned n_accepted, n_results, n_errors, n_ramp, n_hold, n_zero_acc;
  int unsigned hold_cnt;
  bit          hold_done;

  // ---------------------------------------------------------------- predictor
  function automatic longint sat32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // shift right rounding toward minus infinity, sign given apart from magnitude
  function automatic longint floor_shr(input bit neg, input bit [63:0] mag, input int sh);
    bit [63:0] q;
    if (neg) begin
      q = (mag + ((64'd1 << sh) - 64'd1)) >> sh;
      return -longint'(q);
    end
    q = mag >> sh;
    return longint'(q);
  endfunction

  function automatic longint ramp_velocity(input longint v0, input bit up,
                                           input bit [63:0] acc, input bit [63:0] t);
    bit [63:0] d;
    d = (acc * t) >> 16;
    return up ? v0 + longint'(d) : v0 - longint'(d);
  endfunction

  // trapezoid: p0 + (v0 + v) * t / 2, products wrap at 64 bits
  function automatic longint ramp_position(input longint p0, input longint v0,
                                           input longint v, input bit [63:0] t);
    longint    s;
    bit        neg;
    bit [63:0] mag, prod;
    s    = v0 + v;
    neg  = s < 0;
    mag  = neg ? 64'(-s) : 64'(s);
    prod = mag * t;
    return sat32(p0 + floor_shr(neg, prod, 17));
  endfunction

  function automatic vrts_pkg::out_word_t predict_sample(input vrts_pkg::in_word_t w);
    longint    p0, v0, vt, vend, np, nv, na, pt;
    bit [63:0] acc, t, ramp_t, dv, q, mag, prod;
    bit        sel, up, neg, work, az;
    vrts_pkg::out_word_t r;
    sel  = w.selected && (int'(w.axis) < NUM_AXES);
    p0   = longint'(w.current_position);
    v0   = longint'(w.current_velocity);
    vt   = longint'(w.target_velocity);
    acc  = {32'd0, w.max_accel};
    t    = {32'd0, w.sample_time};
    ramp_t = 0; work = 0; az = 0;
    if (w.first_axis) begin
      set_max_time = '0; set_max_axis = '0; set_working = 1'b0;
    end
    if (!sel) begin
      np = p0; nv = v0; na = longint'(w.current_accel); pt = p0;
    end else begin
      up = v0 <= vt;
      dv = up ? 64'(vt - v0) : 64'(v0 - vt);
      if (acc == 0) begin
        ramp_t = 64'hFFFF_FFFF;
        az = 1'b1;
      end else begin
        q = (dv << 16) / acc;
        ramp_t = (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
      end
      vend = ramp_velocity(v0, up, acc, ramp_t);
      pt   = ramp_position(p0, v0, vend, ramp_t);
      if (t <= ramp_t) begin
        nv = ramp_velocity(v0, up, acc, t);
        np = ramp_position(p0, v0, nv, t);
        if (up) na = (acc > 64'h7FFF_FFFF) ? S32_MAX : longint'(acc);
        else    na = (acc > 64'h8000_0000) ? S32_MIN : -longint'(acc);
        work = 1'b1;
      end else begin
        // hold at the velocity reached at ramp end
        neg  = vend < 0;
        mag  = neg ? 64'(-vend) : 64'(vend);
        prod = mag * (t - ramp_t);
        np   = sat32(pt + floor_shr(neg, prod, 16));
        nv   = vend;
        na   = 0;
      end
      if (ramp_t[31:0] > set_max_time) begin   // strictly greater only
        set_max_time = ramp_t[31:0];
        set_max_axis = w.axis;
      end
      set_working |= work;
    end
    r.axis_out           = w.axis;
    r.new_position       = np[31:0];
    r.new_velocity       = nv[31:0];
    r.new_accel          = na[31:0];
    r.position_at_target = pt[31:0];
    r.ramp_time          = ramp_t[31:0];
    r.working            = work;
    r.any_working        = set_working;
    r.greatest_time      = set_max_time;
    r.greatest_axis      = set_max_axis;
    r.accel_zero         = az;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic vrts_pkg::in_word_t make_word(input bit [2:0] ax, input bit first,
                                                   input bit sel,
                                                   input bit [31:0] p, input bit [31:0] v,
                                                   input bit [31:0] ac, input bit [31:0] vt,
                                                   input bit [31:0] amax, input bit [31:0] t);
    vrts_pkg::in_word_t w;
    w.axis = ax; w.first_axis = first; w.selected = sel;
    w.current_position = p; w.current_velocity = v; w.current_accel = ac;
    w.target_velocity = vt; w.max_accel = amax; w.sample_time = t;
    return w;
  endfunction

  // signed value in +/- 2^bits
  function automatic bit [31:0] near_zero(input int bits);
    return 32'($urandom_range(0, (1 << (bits + 1)) - 1)) - (32'd1 << bits);
  endfunction

  // mostly realistic ramps, half sampled around their end, some zero limits, the rest raw noise
  function automatic vrts_pkg::in_word_t random_word();
    vrts_pkg::in_word_t w;
    bit [223:0]  raw;
    int unsigned pick;
    bit [31:0]   v0, vt, acc, t, span;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(vrts_pkg::in_word_t)-1:0];
    w.first_axis = ($urandom_range(0, 4) == 0);
    w.selected   = ($urandom_range(0, 7) != 0);
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      v0  = near_zero($urandom_range(8, 24));
      vt  = near_zero($urandom_range(8, 24));
      acc = $urandom_range(1, 1 << $urandom_range(4, 24));
      span = (v0 > vt) ? v0 - vt : vt - v0;
      // half the time aim the sample time near the ramp end
      t = ($urandom_range(0, 1)) ? $urandom_range(0, 1 << 20)
                                 : 32'(({32'd0, span} << 16) / acc) + near_zero(8);
      w.current_position = near_zero($urandom_range(8, 30));
      w.current_velocity = v0;
      w.target_velocity  = vt;
      w.max_accel        = acc;
      w.sample_time      = t;
    end else if (pick == 7) begin
      w.max_accel = '0;
      w.current_velocity = near_zero(12);
      w.sample_time = $urandom_range(0, 1 << 20);
    end
    return w;
  endfunction

  task automatic load_directed();
    // zero acceleration limit, opening a set
    pending_words.push_back(make_word(0, 1, 1, 0, 32'h0001_0000, 0, 32'h0005_0000, 0,
                                      32'h0002_0000));
    // one second ramp, sampled at start, at the end and just past it
    pending_words.push_back(make_word(1, 0, 1, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0));
    pending_words.push_back(make_word(2, 0, 1, 0, 0, 0, 32'h0001_0000, 32'h0001_0000,
                                      32'h0001_0000));
    pending_words.push_back(make_word(3, 0, 1, 0, 0, 0, 32'h0001_0000, 32'h0001_0000,
                                      32'h0001_0001));
    // tie on ramp time keeps the earlier axis
    pending_words.push_back(make_word(4, 1, 1, 5, 0, 0, 32'h0001_0000, 32'h0001_0000,
                                      32'h0003_0000));
    pending_words.push_back(make_word(5, 0, 1, 5, 0, 0, 32'hFFFF_0000, 32'h0001_0000,
                                      32'h0003_0000));
    // equal velocities: zero ramp time, all ramp times zero keep axis 0
    pending_words.push_back(make_word(6, 1, 1, 7, 32'h0002_0000, 0, 32'h0002_0000,
                                      32'h0001_0000, 0));
    pending_words.push_back(make_word(7, 0, 1, 7, 32'h0002_0000, 0, 32'h0002_0000,
                                      32'h0001_0000, 32'hFFFF_FFFF));
    // velocity extremes, both directions, largest limit and limits around 2^31
    pending_words.push_back(make_word(1, 1, 1, 32'h8000_0000, 32'h8000_0000, 0,
                                      32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(2, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
                                      32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_8000));
    pending_words.push_back(make_word(3, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
                                      32'h8000_0000, 32'h8000_0000, 0));
    pending_words.push_back(make_word(4, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
                                      32'h8000_0000, 32'h8000_0001, 32'h0000_0001));
    // saturating ramp time and position
    pending_words.push_back(make_word(5, 0, 1, 32'h7FFF_0000, 32'h8000_0000, 0,
                                      32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(6, 0, 1, 32'h8000_0000, 32'hFFFF_0000, 0,
                                      32'hFFFF_0000, 32'h0000_0001, 32'hFFFF_FFFF));
    // long hold at a negative velocity, saturating low
    pending_words.push_back(make_word(7, 0, 1, 32'h8001_0000, 0, 0, 32'h8000_0000,
                                      32'h7FFF_FFFF, 32'hFFFF_FFFF));
    // unselected axes pass through, extremes in every field
    pending_words.push_back(make_word(7, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(0, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 0, 0));
    pending_words.push_back(make_word(3, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // ---------------------------------------------------------------- driver
  // Prediction happens at the acceptance edge; the next word goes out at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_samples.push_back(predict_sample(in_word));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // One long hold-off after a few hundred words, so the block backs up into its input.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_cnt > 0) begin
        out_stall <= 1'b1;
        hold_cnt  <= hold_cnt - 1;
      end else if (!hold_done && n_accepted >= 300) begin
        hold_done <= 1'b1;
        hold_cnt  <= 600;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic flag_mismatch(input string field, input bit [63:0] got, input bit [63:0] want);
    n_errors++;
    if (n_errors <= 40)
      $display("%0t result %0d: %s got %h want %h", $realtime, n_results, field, got, want);
  endtask

  always @(posedge clk) begin
    vrts_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        flag_mismatch("unexpected word", 64'(out_word.axis_out), 64'd0);
      end else begin
        want = expected_samples.pop_front();
        if (out_word.axis_out !== want.axis_out)
          flag_mismatch("axis_out", 64'(out_word.axis_out), 64'(want.axis_out));
        if (out_word.new_position !== want.new_position)
          flag_mismatch("new_position", 64'(out_word.new_position),
                        64'(want.new_position));
        if (out_word.new_velocity !== want.new_velocity)
          flag_mismatch("new_velocity", 64'(out_word.new_velocity),
                        64'(want.new_velocity));
        if (out_word.new_accel !== want.new_accel)
          flag_mismatch("new_accel", 64'(out_word.new_accel), 64'(want.new_accel));
        if (out_word.position_at_target !== want.position_at_target)
          flag_mismatch("position_at_target", 64'(out_word.position_at_target),
                        64'(want.position_at_target));
        if (out_word.ramp_time !== want.ramp_time)
          flag_mismatch("ramp_time", 64'(out_word.ramp_time), 64'(want.ramp_time));
        if (out_word.working !== want.working)
          flag_mismatch("working", 64'(out_word.working), 64'(want.working));
        if (out_word.any_working !== want.any_working)
          flag_mismatch("any_working", 64'(out_word.any_working), 64'(want.any_working));
        if (out_word.greatest_time !== want.greatest_time)
          flag_mismatch("greatest_time", 64'(out_word.greatest_time),
                        64'(want.greatest_time));
        if (out_word.greatest_axis !== want.greatest_axis)
          flag_mismatch("greatest_axis", 64'(out_word.greatest_axis),
                        64'(want.greatest_axis));
        if (out_word.accel_zero !== want.accel_zero)
          flag_mismatch("accel_zero", 64'(out_word.accel_zero), 64'(want.accel_zero));
        if (want.accel_zero) n_zero_acc++;
        else if (want.working) n_ramp++;
        else if (want.ramp_time != 0 || want.new_accel == 0) n_hold++;
      end
      n_results++;
    end
  end

  // ---------------------------------------------------------------- sequence
  int unsigned total_words;

  initial begin
    load_directed();
    repeat (N_RANDOM) pending_words.push_back(random_word());
    total_words = pending_words.size();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // idling phases: sender light / receiver heavy, swapped, then none
    wait (n_accepted >= total_words / 3);
    send_idle_pct = 46; recv_idle_pct = 16;
    wait (n_accepted >= 2 * total_words / 3);
    send_idle_pct = 0; recv_idle_pct = 0;

    wait (pending_words.size() == 0 && n_accepted == total_words);
    wait (expected_samples.size() == 0);
    repeat (200) @(posedge clk);   // room for stray words to show up

    $display("words %0d, results %0d: ramp %0d, hold/pass %0d, zero limit %0d",
             n_accepted, n_results, n_ramp, n_hold, n_zero_acc);
    $display("phases: sender-heavy, receiver-heavy, no idling, one long output hold-off");
    if (n_errors == 0)
      $display("velocity_ramp_trajectory_sampler_tb: clean");
    else
      $display("velocity_ramp_trajectory_sampler_tb: errors");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout with %0d words still expected", expected_samples.size());
    $display("velocity_ramp_trajectory_sampler_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
design/vrts_pkg.sv
design/vrts_ctrl.sv
design/vrts_datapath.sv
design/velocity_ramp_trajectory_sampler.sv
tb/velocity_ramp_trajectory_sampler_tb.sv
